// ===== rtl/sm4_pkg.sv =====
// ---------------------------------------------------------------------------
// SM4 package
// S-box, system constants and the shared types of the SM4 engine.
// ---------------------------------------------------------------------------
package sm4_pkg;

	localparam logic [1:0] MODE_ECB = 2'd0;
	localparam logic [1:0] MODE_CBC = 2'd1;
	localparam logic [1:0] MODE_CFB = 2'd2;
	localparam logic [1:0] MODE_OFB = 2'd3;

	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_DECRYPT = 3'd1;
	localparam logic [2:0] REG_KEY_HI  = 3'd2;
	localparam logic [2:0] REG_KEY_LO  = 3'd3;
	localparam logic [2:0] REG_IV_HI   = 3'd4;
	localparam logic [2:0] REG_IV_LO   = 3'd5;

	localparam logic [31:0] FK0 = 32'ha3b1bac6;
	localparam logic [31:0] FK1 = 32'h56aa3350;
	localparam logic [31:0] FK2 = 32'h677d9197;
	localparam logic [31:0] FK3 = 32'hb27022dc;

	// Round unit control: key-schedule step or data round.
	typedef struct packed {
		logic        key_sched;
		logic [31:0] rk;
	} sm4_round_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
	8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
	8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
	8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
	8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
	8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
	8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
	8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
	8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
	8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
	8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
	8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
	8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
	8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
	8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
	8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
	8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};

	// CK word for step i: byte j is (4i+j)*7 mod 256.
	function automatic logic [31:0] ck_word(input logic [4:0] i);
		logic [7:0] b;
		b = {1'b0, i, 2'b00} * 8'd7;
		return {b, b + 8'd7, b + 8'd14, b + 8'd21};
	endfunction

endpackage

// ===== rtl/sm4_round.sv =====
// ---------------------------------------------------------------------------
// SM4 round unit
// One round of the key schedule or of the cipher: shift the four-word state.
// ---------------------------------------------------------------------------
module sm4_round (
	input  logic [127:0]          state_in,
	input  sm4_pkg::sm4_round_ctl_t ctl,
	output logic [127:0]          state_out
);
	import sm4_pkg::*;

	logic [31:0] x0, mix, s, l;

	always_comb begin
		x0  = state_in[127:96];
		mix = state_in[95:64] ^ state_in[63:32] ^ state_in[31:0] ^ ctl.rk;
		s   = {SBOX[mix[31:24]], SBOX[mix[23:16]], SBOX[mix[15:8]], SBOX[mix[7:0]]};
		if (ctl.key_sched) begin
			l = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};
		end else begin
			l = s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]} ^ {s[13:0], s[31:14]}
				^ {s[7:0], s[31:8]};
		end
		state_out = {state_in[95:0], x0 ^ l};
	end

endmodule

// ===== rtl/sm4_block_cipher_modes.sv =====
// ---------------------------------------------------------------------------
// SM4 block cipher engine
// ECB, CBC, CFB and OFB on 128-bit blocks with a shared round unit.
// ---------------------------------------------------------------------------
// One round unit runs one round per cycle. With the result taken at once, a
// block passes from one accepted input word to the next through the load
// step, the rounds, and the step in which the result word is taken. After a
// key write the first block also passes through the key-schedule rounds and a
// reload step. ECB or CBC partial blocks and empty CFB/OFB blocks finish
// without rounds. The input is not ready while a block is at work; the result
// sits in an output register until taken.
module sm4_block_cipher_modes #(
	parameter int ROUND_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic [4:0]  byte_count,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic [4:0]  out_count,
	output logic        status
);
	import sm4_pkg::*;

	localparam int RW = $clog2(ROUND_COUNT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_KEYS = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]   state_q;
	logic [RW-1:0] rnd_q;
	logic [1:0]   mode_q;
	logic         dec_q, keys_valid_q;
	logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic [63:0]  chain_hi_q, chain_lo_q;
	logic [127:0] work_q;
	logic [63:0]  bh_q, bl_q;
	logic [4:0]   cnt_q;
	logic         rev_q;
	logic [31:0]  rk_mem [ROUND_COUNT];
	logic [31:0]  rk_rd_q;
	logic [127:0] round_out;
	sm4_round_ctl_t ctl;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid;
	assign cfg_ready = 1'b1;

	logic [63:0]  cur_hi, cur_lo;
	logic [4:0]   n_sat;
	logic         chain_mode;
	always_comb begin
		cur_hi = restart ? iv_hi_q : chain_hi_q;
		cur_lo = restart ? iv_lo_q : chain_lo_q;
		n_sat  = byte_count[4] ? 5'd16 : byte_count;
		chain_mode = mode_q[1];
	end

	// Round key read: registered, address one step ahead of the round.
	// Outside the rounds, fetch the first key of the coming block.
	logic [RW-1:0] rd_addr;
	logic [RW-1:0] next_rnd;
	logic          rd_rev;
	always_comb begin
		next_rnd = (state_q == ST_RUN) ? rnd_q + 1'b1 : '0;
		rd_rev   = (state_q == ST_RUN) ? rev_q : (!chain_mode && dec_q);
		rd_addr  = rd_rev ? RW'(ROUND_COUNT - 1) - next_rnd : next_rnd;
	end

	always_comb begin
		ctl.key_sched = (state_q == ST_KEYS);
		ctl.rk        = ctl.key_sched ? ck_word(5'(rnd_q)) : rk_rd_q;
	end

	sm4_round u_round (.state_in(work_q), .ctl(ctl), .state_out(round_out));

	always_ff @(posedge clk) begin
		if (state_q == ST_KEYS) begin
			rk_mem[rnd_q] <= round_out[31:0];
		end
		rk_rd_q <= rk_mem[rd_addr];
	end

	// Output masks for partial blocks, and the masked result words.
	logic [63:0]  mh, ml, kh, kl, rh, rl;
	always_comb begin
		mh = '0;
		ml = '0;
		for (int i = 0; i < 8; i++) begin
			mh[63-8*i -: 8] = (cnt_q > 5'(i))     ? 8'hff : 8'h00;
			ml[63-8*i -: 8] = (cnt_q > 5'(i + 8)) ? 8'hff : 8'h00;
		end
		kh = {round_out[31:0], round_out[63:32]};
		kl = {round_out[95:64], round_out[127:96]};
		rh = (bh_q ^ kh) & mh;
		rl = (bl_q ^ kl) & ml;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rnd_q        <= '0;
			mode_q       <= MODE_ECB;
			dec_q        <= 1'b0;
			keys_valid_q <= 1'b0;
			key_hi_q     <= '0;
			key_lo_q     <= '0;
			iv_hi_q      <= '0;
			iv_lo_q      <= '0;
			chain_hi_q   <= '0;
			chain_lo_q   <= '0;
			out_valid    <= 1'b0;
			rev_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MODE:    mode_q <= cfg_data[1:0];
					REG_DECRYPT: dec_q  <= cfg_data[0];
					REG_KEY_HI: begin
						key_hi_q     <= cfg_data;
						keys_valid_q <= 1'b0;
					end
					REG_KEY_LO: begin
						key_lo_q     <= cfg_data;
						keys_valid_q <= 1'b0;
					end
					REG_IV_HI:   iv_hi_q <= cfg_data;
					REG_IV_LO:   iv_lo_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						chain_hi_q <= cur_hi;
						chain_lo_q <= cur_lo;
						rnd_q      <= '0;
						if (!chain_mode && n_sat != 5'd16) begin
							// ECB/CBC partial block: error, no rounds
							out_valid <= 1'b1;
						end else if (chain_mode && n_sat == 5'd0) begin
							out_valid <= 1'b1;
						end else if (!keys_valid_q) begin
							state_q <= ST_KEYS;
							rev_q   <= 1'b0;
						end else begin
							state_q <= ST_RUN;
							rev_q   <= !chain_mode && dec_q;
						end
					end
				end
				ST_KEYS: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RW'(ROUND_COUNT - 1)) begin
						keys_valid_q <= 1'b1;
						state_q      <= ST_DONE;
						rev_q        <= !chain_mode && dec_q;
					end
				end
				ST_DONE: begin
					// Reload the data path after the key schedule.
					state_q <= ST_RUN;
					rnd_q   <= '0;
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RW'(ROUND_COUNT - 1)) begin
						state_q   <= ST_IDLE;
						out_valid <= 1'b1;
						unique case (mode_q)
							MODE_ECB: ;
							MODE_CBC: begin
								if (dec_q) begin
									chain_hi_q <= bh_q;
									chain_lo_q <= bl_q;
								end else begin
									chain_hi_q <= kh;
									chain_lo_q <= kl;
								end
							end
							MODE_CFB: begin
								chain_hi_q <= (kh & ~mh) | (dec_q ? (bh_q & mh) : rh);
								chain_lo_q <= (kl & ~ml) | (dec_q ? (bl_q & ml) : rl);
							end
							default: begin
								chain_hi_q <= kh;
								chain_lo_q <= kl;
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Data path loads: work register, held block, output word.
	logic [127:0] load_val;
	always_comb begin
		if (chain_mode) begin
			load_val = {chain_hi_q, chain_lo_q};
		end else if (mode_q == MODE_CBC && !dec_q) begin
			load_val = {bh_q ^ chain_hi_q, bl_q ^ chain_lo_q};
		end else begin
			load_val = {bh_q, bl_q};
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					bh_q  <= block_high;
					bl_q  <= block_low;
					cnt_q <= n_sat;
					if (!keys_valid_q && !(!chain_mode && n_sat != 5'd16)
						&& !(chain_mode && n_sat == 5'd0)) begin
						work_q <= {key_hi_q[63:32] ^ FK0, key_hi_q[31:0] ^ FK1,
							key_lo_q[63:32] ^ FK2, key_lo_q[31:0] ^ FK3};
					end else if (chain_mode) begin
						work_q <= {cur_hi, cur_lo};
					end else if (mode_q == MODE_CBC && !dec_q) begin
						work_q <= {block_high ^ cur_hi, block_low ^ cur_lo};
					end else begin
						work_q <= {block_high, block_low};
					end
					out_high  <= '0;
					out_low   <= '0;
					out_count <= '0;
					status    <= !chain_mode && n_sat != 5'd16;
				end
			end
			ST_KEYS: work_q <= round_out;
			ST_DONE: work_q <= load_val;
			ST_RUN: begin
				work_q <= round_out;
				if (rnd_q == RW'(ROUND_COUNT - 1)) begin
					status <= 1'b0;
					if (chain_mode) begin
						out_high  <= rh;
						out_low   <= rl;
						out_count <= cnt_q;
					end else if (mode_q == MODE_CBC && dec_q) begin
						out_high  <= kh ^ chain_hi_q;
						out_low   <= kl ^ chain_lo_q;
						out_count <= 5'd16;
					end else begin
						out_high  <= kh;
						out_low   <= kl;
						out_count <= 5'd16;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("input ready while busy");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> out_count == 5'd0) else $error("error with data");
	a_keys_then_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> state_q == ST_RUN) else $error("bad key handoff");
	a_run_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && rnd_q == RW'(ROUND_COUNT - 1) |=> out_valid)
		else $error("round end without result");
`endif

endmodule

// ===== tb/sm4_block_cipher_modes_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SM4 block cipher engine test
// Writes key, IV, mode and direction between phases, streams blocks through
// the engine with random gaps on both sides, and checks every result word
// against a behavioral SM4 model kept in the scoreboard.
// ---------------------------------------------------------------------------
module sm4_block_cipher_modes_test;
	import sm4_pkg::*;

	class sm4_scoreboard;
		logic [1:0]  mode;
		logic        dec;
		logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
		logic [31:0] rkeys [32];
		logic        rk_ok;
		logic [63:0] chain_hi, chain_lo;
		logic [63:0] exp_hi [$];
		logic [63:0] exp_lo [$];
		logic [4:0]  exp_cnt [$];
		logic        exp_st [$];
		int          errors;

		function new();
			mode = MODE_ECB; dec = 0;
			key_hi = 0; key_lo = 0; iv_hi = 0; iv_lo = 0;
			rk_ok = 0; chain_hi = 0; chain_lo = 0; errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] d);
			case (idx)
				REG_MODE:    mode = d[1:0];
				REG_DECRYPT: dec = d[0];
				REG_KEY_HI:  begin key_hi = d; rk_ok = 0; end
				REG_KEY_LO:  begin key_lo = d; rk_ok = 0; end
				REG_IV_HI:   iv_hi = d;
				REG_IV_LO:   iv_lo = d;
				default: ;
			endcase
		endfunction

		function logic [31:0] tau(logic [31:0] x);
			return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
		endfunction

		function logic [31:0] rol(logic [31:0] x, int n);
			return (x << n) | (x >> (32 - n));
		endfunction

		function void schedule_keys();
			logic [31:0] k [4];
			logic [31:0] t, ck;
			logic [7:0]  b;
			k[0] = key_hi[63:32] ^ 32'ha3b1bac6;
			k[1] = key_hi[31:0]  ^ 32'h56aa3350;
			k[2] = key_lo[63:32] ^ 32'h677d9197;
			k[3] = key_lo[31:0]  ^ 32'hb27022dc;
			for (int i = 0; i < 32; i++) begin
				ck = 0;
				for (int j = 0; j < 4; j++) begin
					b = 8'((4 * i + j) * 7);
					ck = {ck[23:0], b};
				end
				t = tau(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ ck);
				t = t ^ rol(t, 13) ^ rol(t, 23);
				k[i % 4] ^= t;
				rkeys[i] = k[i % 4];
			end
			rk_ok = 1;
		endfunction

		function logic [127:0] encipher(logic [127:0] blk, logic rev);
			logic [31:0] x [4];
			logic [31:0] t;
			x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
			for (int i = 0; i < 32; i++) begin
				t = tau(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4]
					^ rkeys[rev ? 31 - i : i]);
				x[i % 4] ^= t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
			end
			return {x[3], x[2], x[1], x[0]};
		endfunction

		// Note one accepted block word and queue its expected result.
		function void note_block(logic [63:0] bh, logic [63:0] bl, logic [4:0] cnt,
				logic rst);
			logic [127:0] d, r, m, ks, nc;
			int n;
			d = {bh, bl};
			r = 0;
			n = (cnt > 16) ? 16 : cnt;
			if (rst) begin chain_hi = iv_hi; chain_lo = iv_lo; end
			if (!rk_ok) schedule_keys();
			if (mode == MODE_ECB || mode == MODE_CBC) begin
				if (n != 16) begin
					push(0, 0, 0, 1);
					return;
				end
				if (mode == MODE_ECB) r = encipher(d, dec);
				else if (!dec) begin
					r = encipher(d ^ {chain_hi, chain_lo}, 0);
					{chain_hi, chain_lo} = r;
				end else begin
					r = encipher(d, 1) ^ {chain_hi, chain_lo};
					{chain_hi, chain_lo} = d;
				end
				push(r[127:64], r[63:0], 16, 0);
				return;
			end
			if (n == 0) begin
				push(0, 0, 0, 0);
				return;
			end
			m = ~(128'h0) << (128 - 8 * n);
			if (n == 16) m = ~(128'h0);
			ks = encipher({chain_hi, chain_lo}, 0);
			r = (d ^ ks) & m;
			if (mode == MODE_CFB) nc = (ks & ~m) | (dec ? (d & m) : r);
			else nc = ks;
			{chain_hi, chain_lo} = nc;
			push(r[127:64], r[63:0], 5'(n), 0);
		endfunction

		function void push(logic [63:0] h, logic [63:0] l, logic [4:0] c, logic s);
			exp_hi.push_back(h); exp_lo.push_back(l);
			exp_cnt.push_back(c); exp_st.push_back(s);
		endfunction

		function void check_result(logic [63:0] h, logic [63:0] l, logic [4:0] c, logic s);
			if (exp_hi.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h %h %0d %0d", h, l, c, s);
				return;
			end
			if (h !== exp_hi[0] || l !== exp_lo[0] || c !== exp_cnt[0] || s !== exp_st[0]) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %h %h cnt %0d st %0d, got %h %h cnt %0d st %0d",
						exp_hi[0], exp_lo[0], exp_cnt[0], exp_st[0], h, l, c, s);
			end
			void'(exp_hi.pop_front()); void'(exp_lo.pop_front());
			void'(exp_cnt.pop_front()); void'(exp_st.pop_front());
		endfunction

		function int pending();
			return exp_hi.size();
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 0;
	logic [63:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [63:0] block_high = 0;
	logic [63:0] block_low = 0;
	logic [4:0]  byte_count = 0;
	logic        restart = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [63:0] out_high;
	logic [63:0] out_low;
	logic [4:0]  out_count;
	logic        status;

	sm4_scoreboard sb = new();
	int  cycles = 0;
	bit  long_stall = 0;

	sm4_block_cipher_modes dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("sm4_block_cipher_modes_test NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_high, out_low, out_count, status);

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				long_stall = 0;
			end
			g = gap_len();
			if (g == 0 || $urandom_range(0, 3) == 0) out_ready <= 1;
			else begin
				out_ready <= 0;
				repeat (g) @(negedge clk);
				out_ready <= 1;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] d);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_block(logic [63:0] bh, logic [63:0] bl, logic [4:0] cnt,
			logic rst, bit gaps);
		int g;
		if (gaps) begin
			g = gap_len();
			repeat (g) @(negedge clk);
		end
		in_valid <= 1; block_high <= bh; block_low <= bl;
		byte_count <= cnt; restart <= rst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_block(bh, bl, cnt, rst);
		@(negedge clk);
		in_valid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		int w;
		w = 0;
		while (sb.pending() != 0 && w < 100000) begin
			@(negedge clk);
			w++;
		end
		repeat (80) @(negedge clk);
	endtask

	task automatic setup(logic [1:0] m, logic d, bit new_key, bit extreme);
		logic [63:0] v [4];
		for (int i = 0; i < 4; i++)
			v[i] = extreme ? ($urandom_range(0, 1) ? '1 : '0) : {$urandom, $urandom};
		write_reg(REG_MODE, 64'(m));
		write_reg(REG_DECRYPT, 64'(d));
		if (new_key) begin
			write_reg(REG_KEY_HI, v[0]);
			write_reg(REG_KEY_LO, v[1]);
		end
		write_reg(REG_IV_HI, v[2]);
		write_reg(REG_IV_LO, v[3]);
	endtask

	function logic [4:0] rand_count(logic [1:0] m);
		int r;
		r = $urandom_range(0, 99);
		if (m == MODE_ECB || m == MODE_CBC) return (r < 85) ? 16 : 5'($urandom_range(0, 31));
		if (r < 50) return 16;
		if (r < 90) return 5'($urandom_range(1, 15));
		return 5'($urandom_range(0, 31));
	endfunction

	initial begin
		logic [1:0] m;
		int len;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Known-answer vector first, then three blocks per mode and direction.
		write_reg(REG_KEY_HI, 64'h0123456789abcdef);
		write_reg(REG_KEY_LO, 64'hfedcba9876543210);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 16, 0, 0);
		drain();
		for (int i = 0; i < 8; i++) begin
			setup(2'(i / 2), 1'(i % 2), i == 4, i % 3 == 0);
			send_block('1, '1, 16, 1, 0);
			send_block('0, '0, 16, 0, 0);
			send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'(i + 1), 0, 0);
			drain();
		end
		// Odd counts: zero, above sixteen, in CFB and ECB.
		setup(MODE_CFB, 0, 0, 0);
		send_block('1, '1, 0, 1, 0);
		send_block('1, '1, 31, 0, 0);
		send_block('1, '1, 17, 0, 0);
		drain();
		setup(MODE_ECB, 1, 0, 0);
		send_block('1, '1, 0, 1, 0);
		send_block('1, '1, 31, 0, 0);
		drain();

		// Random phases: streams of random counts with restart at the head.
		for (int p = 0; p < 50; p++) begin
			m = 2'($urandom_range(0, 3));
			setup(m, 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0,
				$urandom_range(0, 7) == 0);
			len = $urandom_range(20, 45);
			if (p == 10) long_stall = 1;
			for (int i = 0; i < len; i++)
				send_block({$urandom, $urandom}, {$urandom, $urandom}, rand_count(m),
					i == 0 || $urandom_range(0, 15) == 0, !(p == 10 || p % 7 == 3));
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("sm4_block_cipher_modes_test OK");
		else
			$display("sm4_block_cipher_modes_test NOT OK");
		$finish;
	end
endmodule
